// ===== hw/rtl/nfcd_pkg.sv =====
// Package for the NOR flash command decoder: payload structs, command codes,
// sequence stage encoding and the bus data codes. No dependencies.
`default_nettype none

package nfcd_pkg;

  localparam int unsigned AddrW = 20;
  localparam int unsigned DataW = 16;
  localparam int unsigned CmdW  = 4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgFirstUnlock  = 2'd0,
    CfgSecondUnlock = 2'd1,
    CfgCompareMask  = 2'd2,
    CfgUnused       = 2'd3
  } cfg_idx_e;

  // Decoded commands
  typedef enum logic [CmdW-1:0] {
    CmdNone        = 4'd0,
    CmdReset       = 4'd1,
    CmdAutoselect  = 4'd2,
    CmdProgram     = 4'd3,
    CmdSectorErase = 4'd4,
    CmdChipErase   = 4'd5,
    CmdBufWord     = 4'd6,
    CmdBufCommit   = 4'd7,
    CmdAbort       = 4'd8
  } cmd_e;

  // Sequence stages, one-hot
  typedef enum logic [9:0] {
    StIdle        = 10'b00_0000_0001,
    StUnlock1     = 10'b00_0000_0010,
    StUnlock2     = 10'b00_0000_0100,
    StProgram     = 10'b00_0000_1000,
    StEraseUnlk0  = 10'b00_0001_0000,
    StEraseUnlk1  = 10'b00_0010_0000,
    StEraseCmd    = 10'b00_0100_0000,
    StBufCount    = 10'b00_1000_0000,
    StBufData     = 10'b01_0000_0000,
    StBufCommit   = 10'b10_0000_0000
  } stage_e;

  // Bus data codes
  localparam logic [DataW-1:0] DatUnlockA   = 16'h00AA;
  localparam logic [DataW-1:0] DatUnlockB   = 16'h0055;
  localparam logic [DataW-1:0] DatAutosel   = 16'h0090;
  localparam logic [DataW-1:0] DatEraseSet  = 16'h0080;
  localparam logic [DataW-1:0] DatChipErase = 16'h0010;
  localparam logic [DataW-1:0] DatSectErase = 16'h0030;
  localparam logic [DataW-1:0] DatProgram   = 16'h00A0;
  localparam logic [DataW-1:0] DatBufLoad   = 16'h0025;
  localparam logic [DataW-1:0] DatBufCommit = 16'h0029;
  localparam logic [DataW-1:0] DatReset     = 16'h00F0;

  // Register reset values
  localparam logic [AddrW-1:0] FirstUnlockRst  = 20'h05555;
  localparam logic [AddrW-1:0] SecondUnlockRst = 20'h02AAA;
  localparam logic [AddrW-1:0] CompareMaskRst  = 20'h07FFF;

  typedef struct packed {
    logic [AddrW-1:0] word_address;
    logic [DataW-1:0] write_data;
  } nfcd_in_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [AddrW-1:0] target_address;
    logic [DataW-1:0] target_data;
    logic             autoselect_active;
  } nfcd_out_t;

  typedef struct packed {
    logic [AddrW-1:0] first_unlock;
    logic [AddrW-1:0] second_unlock;
    logic [AddrW-1:0] compare_mask;
  } nfcd_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfcd_cfg_regs.sv =====
// Configuration registers of the NOR flash command decoder.
// Depends on nfcd_pkg for the register indexes and the config struct.
`default_nettype none

module nfcd_cfg_regs
  import nfcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [1:0]       wr_index_i,
  input  wire logic [AddrW-1:0] wr_data_i,
  output nfcd_cfg_t             cfg_o
);

  nfcd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CfgFirstUnlock:  cfg_d.first_unlock  = wr_data_i;
        CfgSecondUnlock: cfg_d.second_unlock = wr_data_i;
        CfgCompareMask:  cfg_d.compare_mask  = wr_data_i;
        default: ; // index past the list: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_unlock  <= FirstUnlockRst;
      cfg_q.second_unlock <= SecondUnlockRst;
      cfg_q.compare_mask  <= CompareMaskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nfcd_seq_fsm.sv =====
// Command sequence state machine: decodes one registered bus write per step
// and holds the sequence state. Depends on nfcd_pkg.
`default_nettype none

module nfcd_seq_fsm
  import nfcd_pkg::*;
#(
  parameter int unsigned BUFFER_MAX_WORDS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire nfcd_in_t  item_i,
  input  wire nfcd_cfg_t cfg_i,
  output nfcd_out_t      res_o
);

  localparam int unsigned CntW = (BUFFER_MAX_WORDS > 1) ? $clog2(BUFFER_MAX_WORDS) : 1;
  localparam logic [DataW-1:0] MaxCount = DataW'(BUFFER_MAX_WORDS - 1);

  stage_e           stage_q, stage_d;
  logic             ident_q, ident_d;
  logic [CntW-1:0]  left_q, left_d;
  logic [AddrW-1:0] base_q, base_d;

  logic             at_first, at_second, data_cycle;
  logic [AddrW-1:0] addr;
  logic [DataW-1:0] data;
  cmd_e             cmd;
  logic [AddrW-1:0] taddr;
  logic [DataW-1:0] tdata;

  assign addr       = item_i.word_address;
  assign data       = item_i.write_data;
  assign at_first   = ((addr ^ cfg_i.first_unlock) & cfg_i.compare_mask) == '0;
  assign at_second  = ((addr ^ cfg_i.second_unlock) & cfg_i.compare_mask) == '0;
  assign data_cycle = (stage_q == StProgram) || (stage_q == StBufData);

  always_comb begin
    stage_d = stage_q;
    ident_d = ident_q;
    left_d  = left_q;
    base_d  = base_q;
    cmd     = CmdNone;
    taddr   = '0;
    tdata   = '0;

    if (!data_cycle && data == DatReset) begin
      cmd     = CmdReset;
      ident_d = 1'b0;
      stage_d = StIdle;
    end else begin
      unique case (stage_q)
        StIdle: begin
          if (data == DatUnlockA && at_first) stage_d = StUnlock1;
        end
        StUnlock1: begin
          if (data == DatUnlockB && at_second) stage_d = StUnlock2;
          else cmd = CmdAbort;
        end
        StUnlock2: begin
          if (data == DatAutosel && at_first) begin
            cmd     = CmdAutoselect;
            ident_d = 1'b1;
            stage_d = StIdle;
          end else if (data == DatProgram && at_first) begin
            stage_d = StProgram;
          end else if (data == DatEraseSet && at_first) begin
            stage_d = StEraseUnlk0;
          end else if (data == DatBufLoad) begin
            // buffer cycles are not checked against the unlock addresses
            base_d  = addr;
            stage_d = StBufCount;
          end else begin
            cmd = CmdAbort;
          end
        end
        StProgram: begin
          cmd     = CmdProgram;
          taddr   = addr;
          tdata   = data;
          stage_d = StIdle;
        end
        StEraseUnlk0: begin
          if (data == DatUnlockA && at_first) stage_d = StEraseUnlk1;
          else cmd = CmdAbort;
        end
        StEraseUnlk1: begin
          if (data == DatUnlockB && at_second) stage_d = StEraseCmd;
          else cmd = CmdAbort;
        end
        StEraseCmd: begin
          if (data == DatChipErase && at_first) begin
            cmd     = CmdChipErase;
            stage_d = StIdle;
          end else if (data == DatSectErase) begin
            cmd     = CmdSectorErase;
            taddr   = addr;
            stage_d = StIdle;
          end else begin
            cmd = CmdAbort;
          end
        end
        StBufCount: begin
          if (data > MaxCount) begin
            cmd = CmdAbort;
          end else begin
            left_d  = data[CntW-1:0];
            stage_d = StBufData;
          end
        end
        StBufData: begin
          cmd   = CmdBufWord;
          taddr = addr;
          tdata = data;
          if (left_q == '0) stage_d = StBufCommit;
          else left_d = CntW'(left_q - 1'b1);
        end
        StBufCommit: begin
          if (data == DatBufCommit) begin
            cmd     = CmdBufCommit;
            taddr   = base_q;
            stage_d = StIdle;
          end else begin
            cmd = CmdAbort;
          end
        end
        default: stage_d = StIdle;
      endcase
      if (cmd == CmdAbort) stage_d = StIdle;
    end
    if (stage_d == StIdle) left_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StIdle;
      ident_q <= 1'b0;
      left_q  <= '0;
      base_q  <= '0;
    end else if (step_i) begin
      stage_q <= stage_d;
      ident_q <= ident_d;
      left_q  <= left_d;
      base_q  <= base_d;
    end
  end

  assign res_o.command           = cmd;
  assign res_o.target_address    = taddr;
  assign res_o.target_data       = tdata;
  assign res_o.autoselect_active = ident_d;

endmodule

`default_nettype wire

// ===== hw/rtl/nor_flash_command_decoder.sv =====
// NOR flash command decoder, top level: input register, sequence decoder and
// result register. Uses nfcd_pkg, nfcd_cfg_regs and nfcd_seq_fsm.
//
// Usage:
//  - in channel: one bus write word (word address, 16-bit data) per handshake.
//  - out channel: exactly one result word per bus write, in order: decoded
//    command, its address/data operands and the identifier mode flag.
//  - cfg channel: writes the unlock addresses and the compare mask; always
//    ready, write only while the decoder is idle.
// Path: an accepted write is held in the input register, then moves into the
// result register, from which the receiver takes it.
// Throughput: one write per cycle while out_ready_i is high; the decode is a
// single pass of logic between the two registers, and the sequence state
// advances as the word moves into the result register.
// Stall: while out_ready_i is low a full result register holds; the input
// register takes one more word if it is empty, then in_ready_o drops.
// Reset: config, sequence and valid flag registers return to reset values,
// the sequence goes idle, identifier mode clears, both pipeline registers empty.
`default_nettype none

module nor_flash_command_decoder
  import nfcd_pkg::*;
#(
  parameter int unsigned BUFFER_MAX_WORDS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire nfcd_in_t         in_word_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output nfcd_out_t             out_word_o,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [AddrW-1:0] cfg_data_i
);

  nfcd_cfg_t cfg;
  nfcd_in_t  in_q;
  logic      in_valid_q;
  nfcd_out_t res, out_q;
  logic      out_valid_q;
  logic      out_free, advance;

  assign cfg_ready_o = 1'b1;

  nfcd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_word_i;
  end

  nfcd_seq_fsm #(
    .BUFFER_MAX_WORDS (BUFFER_MAX_WORDS)
  ) u_fsm (
    .clk_i,
    .rst_ni,
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
